>>> design/bpe_pkg.sv
// Shared types and constants for the bicubic patch evaluator.
// Used by bpe_cubic and bicubic_patch_eval; depends on nothing.
package bpe_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int BASIS_FRAC = 12;
    localparam int OUT_W      = 40;
    localparam int PARAM_W    = 17;
    localparam int ACC_W      = 64;
    localparam int CUBIC_LAT  = 8;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [PARAM_W-1:0]      t_param;
    typedef logic [15:0][15:0]       t_mat;

    localparam t_param PARAM_ONE = t_param'(1 << FRAC_BITS);

    typedef enum logic [1:0] {
        KIND_LOAD_POINT = 2'd0,
        KIND_LOAD_UB    = 2'd1,
        KIND_LOAD_VB    = 2'd2,
        KIND_EVAL       = 2'd3
    } t_kind;
endpackage

>>> design/bicubic_patch_eval.sv
// Throughput: one request per cycle while no result waits unaccepted.
// Two chained 8-stage cubic pipelines (row/column pass, then combine pass) plus a
// saturating output register; the whole pipe holds while a result waits unaccepted.
// Load requests write their store when accepted and give no result.
// Reset (synchronous, active low) clears valid bits only; stores stay undefined until written.
// Depends on bpe_pkg and bpe_cubic.
module bicubic_patch_eval (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic [151:0] i_s_tdata,  // entry_index, coord_x, coord_y, coord_z, basis_coeff,
                                     // u_param, v_param, zero pad
    input  logic [1:0]   i_s_tuser,  // kind
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [359:0] o_m_tdata   // pos_x/y/z, du_x/y/z, dv_x/y/z
);
    localparam int LAT = 2 * bpe_pkg::CUBIC_LAT + 1;
    localparam bpe_pkg::t_acc OUT_MAX = (bpe_pkg::t_acc'(1) <<< (bpe_pkg::OUT_W - 1)) - 1;
    localparam bpe_pkg::t_acc OUT_MIN = -(bpe_pkg::t_acc'(1) <<< (bpe_pkg::OUT_W - 1));

    logic en, acc;
    bpe_pkg::t_kind kind;
    logic [3:0] idx;
    bpe_pkg::t_param n_u, n_v;

    logic signed [31:0] r_cp [3][16];
    bpe_pkg::t_mat r_ub, r_vb;
    bpe_pkg::t_mat r_ubd [bpe_pkg::CUBIC_LAT];
    bpe_pkg::t_mat r_vbd [bpe_pkg::CUBIC_LAT];
    bpe_pkg::t_param r_ud [bpe_pkg::CUBIC_LAT];
    bpe_pkg::t_param r_vd [bpe_pkg::CUBIC_LAT];
    logic [LAT-1:0] r_vld;
    logic [359:0] r_out;

    bpe_pkg::t_acc row_val [3][4], row_der [3][4];
    bpe_pkg::t_acc col_val [3][4], col_der [3][4];
    bpe_pkg::t_acc pos [3], dv [3], du [3], unused_du [3];

    assign en   = !o_m_tvalid || i_m_tready;
    assign acc  = i_s_tvalid && en;
    assign kind = bpe_pkg::t_kind'(i_s_tuser);
    assign idx  = i_s_tdata[3:0];
    assign n_u  = (i_s_tdata[132:116] > bpe_pkg::PARAM_ONE) ? bpe_pkg::PARAM_ONE
                                                            : i_s_tdata[132:116];
    assign n_v  = (i_s_tdata[149:133] > bpe_pkg::PARAM_ONE) ? bpe_pkg::PARAM_ONE
                                                            : i_s_tdata[149:133];

    always_ff @(posedge i_clk) begin
        if (acc) begin
            case (kind)
                bpe_pkg::KIND_LOAD_POINT: begin
                    r_cp[0][idx] <= i_s_tdata[35:4];
                    r_cp[1][idx] <= i_s_tdata[67:36];
                    r_cp[2][idx] <= i_s_tdata[99:68];
                end
                bpe_pkg::KIND_LOAD_UB: r_ub[idx] <= i_s_tdata[115:100];
                bpe_pkg::KIND_LOAD_VB: r_vb[idx] <= i_s_tdata[115:100];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ud[0]  <= n_u;
            r_vd[0]  <= n_v;
            r_ubd[0] <= r_ub;
            r_vbd[0] <= r_vb;
            for (int s = 1; s < bpe_pkg::CUBIC_LAT; s++) begin
                r_ud[s]  <= r_ud[s-1];
                r_vd[s]  <= r_vd[s-1];
                r_ubd[s] <= r_ubd[s-1];
                r_vbd[s] <= r_vbd[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], acc && (kind == bpe_pkg::KIND_EVAL)};
        end
    end

    for (genvar ax = 0; ax < 3; ax++) begin : g_axis
        bpe_pkg::t_acc rp [4][4];
        bpe_pkg::t_acc cp [4][4];
        bpe_pkg::t_acc rv [4];
        bpe_pkg::t_acc cv [4];
        for (genvar r = 0; r < 4; r++) begin : g_line
            for (genvar j = 0; j < 4; j++) begin : g_pt
                assign rp[r][j] = bpe_pkg::t_acc'(r_cp[ax][r*4+j]);
                assign cp[r][j] = bpe_pkg::t_acc'(r_cp[ax][j*4+r]);
            end
            bpe_cubic u_row (
                .i_clk(i_clk), .i_en(en), .i_basis(r_ub), .i_p(rp[r]), .i_t(n_u),
                .o_val(row_val[ax][r]), .o_der(row_der[ax][r])
            );
            bpe_cubic u_col (
                .i_clk(i_clk), .i_en(en), .i_basis(r_vb), .i_p(cp[r]), .i_t(n_v),
                .o_val(col_val[ax][r]), .o_der(col_der[ax][r])
            );
            assign rv[r] = row_val[ax][r];
            assign cv[r] = col_val[ax][r];
        end
        bpe_cubic u_comb_v (
            .i_clk(i_clk), .i_en(en), .i_basis(r_vbd[bpe_pkg::CUBIC_LAT-1]), .i_p(rv),
            .i_t(r_vd[bpe_pkg::CUBIC_LAT-1]), .o_val(pos[ax]), .o_der(dv[ax])
        );
        bpe_cubic u_comb_u (
            .i_clk(i_clk), .i_en(en), .i_basis(r_ubd[bpe_pkg::CUBIC_LAT-1]), .i_p(cv),
            .i_t(r_ud[bpe_pkg::CUBIC_LAT-1]), .o_val(unused_du[ax]), .o_der(du[ax])
        );
    end

    function automatic logic [bpe_pkg::OUT_W-1:0] sat(input bpe_pkg::t_acc x);
        bpe_pkg::t_acc y;
        y = (x > OUT_MAX) ? OUT_MAX : ((x < OUT_MIN) ? OUT_MIN : x);
        return y[bpe_pkg::OUT_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= {sat(dv[2]), sat(dv[1]), sat(dv[0]),
                      sat(du[2]), sat(du[1]), sat(du[0]),
                      sat(pos[2]), sat(pos[1]), sat(pos[0])};
        end
    end

    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT-1];
    assign o_m_tdata  = r_out;

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("request taken while pipe stalled");
    a_eval_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && kind == bpe_pkg::KIND_EVAL) |=> r_vld[0])
        else $error("evaluate request lost at pipe entry");
endmodule

>>> design/bpe_cubic.sv
// Pipelined basis-matrix product and cubic evaluation (value and derivative).
// Depends on bpe_pkg; the pipeline advances only while i_en is high.
module bpe_cubic (
    input  logic            i_clk,
    input  logic            i_en,
    input  bpe_pkg::t_mat   i_basis,
    input  bpe_pkg::t_acc   i_p [4],
    input  bpe_pkg::t_param i_t,
    output bpe_pkg::t_acc   o_val,
    output bpe_pkg::t_acc   o_der
);
    function automatic bpe_pkg::t_acc rnd(input bpe_pkg::t_acc x, input int s);
        bpe_pkg::t_acc y;
        y = x + (bpe_pkg::t_acc'(1) <<< (s - 1));
        return y >>> s;
    endfunction

    bpe_pkg::t_acc   r_prod [16];
    bpe_pkg::t_acc   r_a [4];
    bpe_pkg::t_acc   r_mv3, r_md3, r_a1_3, r_a2_3, r_a3_3;
    bpe_pkg::t_acc   r_hv4, r_hd4, r_a2_4, r_a3_4;
    bpe_pkg::t_acc   r_mv5, r_md5, r_a2_5, r_a3_5;
    bpe_pkg::t_acc   r_hv6, r_hd6, r_a3_6;
    bpe_pkg::t_acc   r_mv7, r_hd7, r_a3_7;
    bpe_pkg::t_acc   r_val, r_der;
    bpe_pkg::t_param r_t1, r_t2, r_t3, r_t4, r_t5, r_t6;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[k*4+j] <= bpe_pkg::t_acc'($signed(i_basis[k*4+j])) * i_p[j];
                end
                r_a[k] <= rnd(r_prod[k*4] + r_prod[k*4+1] + r_prod[k*4+2]
                              + r_prod[k*4+3], bpe_pkg::BASIS_FRAC);
            end
            r_t1 <= i_t;
            r_t2 <= r_t1;
            // first Horner product for value and derivative
            r_mv3  <= r_a[0] * $signed({1'b0, r_t2});
            r_md3  <= (r_a[0] * 3) * $signed({1'b0, r_t2});
            r_a1_3 <= r_a[1];
            r_a2_3 <= r_a[2];
            r_a3_3 <= r_a[3];
            r_t3   <= r_t2;
            r_hv4  <= rnd(r_mv3, bpe_pkg::FRAC_BITS) + r_a1_3;
            r_hd4  <= rnd(r_md3, bpe_pkg::FRAC_BITS) + (r_a1_3 <<< 1);
            r_a2_4 <= r_a2_3;
            r_a3_4 <= r_a3_3;
            r_t4   <= r_t3;
            r_mv5  <= r_hv4 * $signed({1'b0, r_t4});
            r_md5  <= r_hd4 * $signed({1'b0, r_t4});
            r_a2_5 <= r_a2_4;
            r_a3_5 <= r_a3_4;
            r_t5   <= r_t4;
            r_hv6  <= rnd(r_mv5, bpe_pkg::FRAC_BITS) + r_a2_5;
            r_hd6  <= rnd(r_md5, bpe_pkg::FRAC_BITS) + r_a2_5;
            r_a3_6 <= r_a3_5;
            r_t6   <= r_t5;
            r_mv7  <= r_hv6 * $signed({1'b0, r_t6});
            r_hd7  <= r_hd6;
            r_a3_7 <= r_a3_6;
            r_val  <= rnd(r_mv7, bpe_pkg::FRAC_BITS) + r_a3_7;
            r_der  <= r_hd7;
        end
    end

    assign o_val = r_val;
    assign o_der = r_der;
endmodule

>>> test/bicubic_patch_eval_test.sv
// Testbench for bicubic_patch_eval: fills the point and basis stores, then runs
// directed and random load/evaluate requests against a built-in fixed-point predictor.
// Depends on bpe_pkg and the bicubic_patch_eval RTL.
module bicubic_patch_eval_test;

    typedef struct {
        bpe_pkg::t_kind kind;
        logic [3:0]     idx;
        logic [31:0]    cx, cy, cz;
        logic [15:0]    coef;
        logic [16:0]    u, v;
        bit             zero_known; // result must be all zero
    } t_request;

    typedef logic [8:0][39:0] t_surface;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [151:0] i_s_tdata = '0;  // entry_index, coord_x, coord_y, coord_z, basis_coeff,
                                   // u_param, v_param, zero pad
    logic [1:0]   i_s_tuser = '0;  // kind
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [359:0] o_m_tdata;       // pos_x/y/z, du_x/y/z, dv_x/y/z
    bit           req_known = 1'b0; // travels with the request on the input side

    bicubic_patch_eval DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser), .o_s_tready(o_s_tready),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    int       pts[48];
    shortint  ubas[16];
    shortint  vbas[16];
    t_surface surface_q[$];
    bit       known_q[$];
    int       fail_cnt = 0;
    int       eval_cnt = 0;
    int       load_cnt = 0;
    int       result_cnt = 0;
    bit       stim_done = 1'b0;
    bit       burst = 1'b0;
    bit       hold_off = 1'b0;
    string    field_names[9] = '{"pos_x", "pos_y", "pos_z", "du_x", "du_y", "du_z",
                                 "dv_x", "dv_y", "dv_z"};

    function automatic longint rnd(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic void basis_mul(bit use_v, input longint p[4], output longint a[4]);
        longint acc;
        for (int k = 0; k < 4; k++) begin
            acc = 0;
            for (int j = 0; j < 4; j++)
                acc += longint'(use_v ? vbas[k*4+j] : ubas[k*4+j]) * p[j];
            a[k] = rnd(acc, bpe_pkg::BASIS_FRAC);
        end
    endfunction

    function automatic longint horner(input longint a[4], longint t, bit slope);
        longint h;
        if (!slope) begin
            h = a[0];
            h = rnd(h * t, bpe_pkg::FRAC_BITS) + a[1];
            h = rnd(h * t, bpe_pkg::FRAC_BITS) + a[2];
            h = rnd(h * t, bpe_pkg::FRAC_BITS) + a[3];
        end else begin
            h = 3 * a[0];
            h = rnd(h * t, bpe_pkg::FRAC_BITS) + 2 * a[1];
            h = rnd(h * t, bpe_pkg::FRAC_BITS) + a[2];
        end
        return h;
    endfunction

    function automatic logic [39:0] clamp40(longint x);
        if (x > 64'sd549755813887)  x = 64'sd549755813887;
        if (x < -64'sd549755813888) x = -64'sd549755813888;
        return x[39:0];
    endfunction

    function automatic t_surface eval_surface(logic [16:0] up, logic [16:0] vp);
        t_surface res;
        longint   u, v;
        longint   rows[4], cols[4], p[4], a[4];
        u = (up > bpe_pkg::PARAM_ONE) ? longint'(bpe_pkg::PARAM_ONE) : longint'(up);
        v = (vp > bpe_pkg::PARAM_ONE) ? longint'(bpe_pkg::PARAM_ONE) : longint'(vp);
        for (int ax = 0; ax < 3; ax++) begin
            for (int r = 0; r < 4; r++) begin
                for (int j = 0; j < 4; j++) p[j] = pts[(r*4+j)*3+ax];
                basis_mul(1'b0, p, a);
                rows[r] = horner(a, u, 1'b0);
                for (int j = 0; j < 4; j++) p[j] = pts[(j*4+r)*3+ax];
                basis_mul(1'b1, p, a);
                cols[r] = horner(a, v, 1'b0);
            end
            basis_mul(1'b1, rows, a);
            res[ax]   = clamp40(horner(a, v, 1'b0));
            res[6+ax] = clamp40(horner(a, v, 1'b1));
            basis_mul(1'b0, cols, a);
            res[3+ax] = clamp40(horner(a, u, 1'b1));
        end
        return res;
    endfunction

    // track accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            case (bpe_pkg::t_kind'(i_s_tuser))
                bpe_pkg::KIND_LOAD_POINT: begin
                    pts[i_s_tdata[3:0]*3+0] = i_s_tdata[35:4];
                    pts[i_s_tdata[3:0]*3+1] = i_s_tdata[67:36];
                    pts[i_s_tdata[3:0]*3+2] = i_s_tdata[99:68];
                    load_cnt++;
                end
                bpe_pkg::KIND_LOAD_UB: begin
                    ubas[i_s_tdata[3:0]] = i_s_tdata[115:100];
                    load_cnt++;
                end
                bpe_pkg::KIND_LOAD_VB: begin
                    vbas[i_s_tdata[3:0]] = i_s_tdata[115:100];
                    load_cnt++;
                end
                bpe_pkg::KIND_EVAL: begin
                    surface_q.push_back(eval_surface(i_s_tdata[132:116], i_s_tdata[149:133]));
                    known_q.push_back(req_known);
                    eval_cnt++;
                end
                default: ;
            endcase
        end
    end

    // check results; rows with a typed-in answer are held to it directly
    always @(posedge i_clk) begin
        t_surface want;
        bit       known;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            result_cnt++;
            if (surface_q.size() == 0) begin
                $error("result with nothing expected");
                fail_cnt++;
            end else begin
                want  = surface_q.pop_front();
                known = known_q.pop_front();
                if (known) want = '0;
                for (int f = 0; f < 9; f++)
                    if (o_m_tdata[f*40 +: 40] !== want[f]) begin
                        $error("%s: expected %0d, got %0d", field_names[f],
                               $signed(want[f]), $signed(o_m_tdata[f*40 +: 40]));
                        fail_cnt++;
                    end
            end
        end
    end

    // result side: random stalls plus one long hold-off
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 16);
            if (hold_off) begin
                i_m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    task automatic send(t_request rq);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= rq.kind;
        i_s_tdata  <= {2'b0, rq.v, rq.u, rq.coef, rq.cz, rq.cy, rq.cx, rq.idx};
        req_known  <= rq.zero_known;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic logic [16:0] rand_param();
        case ($urandom_range(0, 9))
            0:       return 17'($urandom_range(65537, 131071));
            1:       return $urandom_range(0, 1) ? 17'd0 : 17'd65536;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic t_request mk(bpe_pkg::t_kind k, logic [3:0] i, logic [31:0] x,
                                    logic [31:0] y, logic [31:0] z, logic [15:0] c,
                                    logic [16:0] u, logic [16:0] v, bit zk);
        t_request rq;
        rq.kind = k; rq.idx = i; rq.cx = x; rq.cy = y; rq.cz = z;
        rq.coef = c; rq.u = u; rq.v = v; rq.zero_known = zk;
        return rq;
    endfunction

    function automatic t_request rand_request();
        t_request rq;
        int       pick;
        pick = $urandom_range(0, 9);
        rq = mk(bpe_pkg::KIND_EVAL, 4'($urandom()), rand_coord(), rand_coord(), rand_coord(),
                16'($urandom()), rand_param(), rand_param(), 1'b0);
        if (pick == 0)      rq.kind = bpe_pkg::KIND_LOAD_POINT;
        else if (pick == 1) rq.kind = bpe_pkg::KIND_LOAD_UB;
        else if (pick == 2) rq.kind = bpe_pkg::KIND_LOAD_VB;
        if (rq.kind != bpe_pkg::KIND_LOAD_POINT && $urandom_range(0, 1))
            rq.coef = 16'($signed($urandom_range(0, 16384)) - 8192);
        return rq;
    endfunction

    initial begin
        t_request stim_table[$];
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every store entry: random points, zero bases
        for (int e = 0; e < 16; e++) begin
            send(mk(bpe_pkg::KIND_LOAD_POINT, 4'(e), rand_coord(), rand_coord(), rand_coord(),
                    0, 0, 0, 0));
            send(mk(bpe_pkg::KIND_LOAD_UB, 4'(e), 0, 0, 0, 16'h0000, 0, 0, 0));
            send(mk(bpe_pkg::KIND_LOAD_VB, 4'(e), 0, 0, 0, 16'h0000, 0, 0, 0));
        end

        // zero bases give a zero surface; then extremes of coefficients, points and params
        stim_table.push_back(mk(bpe_pkg::KIND_EVAL, 0, 0, 0, 0, 0, 17'd32768, 17'd32768, 1));
        stim_table.push_back(mk(bpe_pkg::KIND_EVAL, 15, 0, 0, 0, 0, 17'h1FFFF, 17'd0, 1));
        stim_table.push_back(mk(bpe_pkg::KIND_LOAD_UB, 0, 0, 0, 0, 16'h7FFF, 0, 0, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_LOAD_UB, 15, 0, 0, 0, 16'h8000, 0, 0, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_LOAD_VB, 0, 0, 0, 0, 16'h8000, 0, 0, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_LOAD_VB, 15, 0, 0, 0, 16'h7FFF, 0, 0, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_LOAD_UB, 5, 0, 0, 0, 16'h1000, 0, 0, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_LOAD_VB, 10, 0, 0, 0, 16'hF000, 0, 0, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_LOAD_POINT, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'hFFFF_FFFF, 0, 0, 0, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_LOAD_POINT, 15, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h0000_0001, 16'hFFFF, 17'h1FFFF, 17'h1FFFF, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_EVAL, 0, 0, 0, 0, 0, 17'd0, 17'd0, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_EVAL, 0, 0, 0, 0, 0, 17'd65536, 17'd65536, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_EVAL, 0, 0, 0, 0, 0, 17'd65536, 17'd0, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_EVAL, 0, 0, 0, 0, 0, 17'd0, 17'd65536, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_EVAL, 0, 0, 0, 0, 0, 17'h1FFFF, 17'd65537, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_EVAL, 0, 0, 0, 0, 0, 17'd65535, 17'd1, 0));
        stim_table.push_back(mk(bpe_pkg::KIND_EVAL, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 16'hFFFF, 17'd32768, 17'd49152, 0));
        foreach (stim_table[n]) send(stim_table[n]);

        for (int n = 0; n < 1900; n++) begin
            if (n % 100 == 0) burst = ($urandom_range(0, 3) == 0);
            if (n == 600) hold_off = 1'b1;
            send(rand_request());
        end
        i_s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (surface_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("covered %0d load and %0d evaluate requests, %0d results checked",
                 load_cnt, eval_cnt, result_cnt);
        $display("parameter extremes, saturation and a long output stall were exercised");
        if (fail_cnt == 0 && surface_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end
endmodule
